@@ hdl/can_frame_ring_fifo_top_assert.svh @@
// Assertion macros for the CAN frame ring FIFO.
`ifndef CAN_FRAME_RING_FIFO_TOP_ASSERT_SVH
`define CAN_FRAME_RING_FIFO_TOP_ASSERT_SVH

// The condition must never hold at a clock edge outside reset.
`define CFRF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define CFRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/cfrf_pkg.sv @@
package cfrf_pkg;

  localparam int unsigned ID_W      = 32;
  localparam int unsigned LEN_IN_W  = 8;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned LEN_MAX   = 64;
  localparam int unsigned PAYLOAD_BYTES = 8;

  localparam logic ST_DONE   = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // One stored frame.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] payload;
    logic [DATA_W-1:0] stamp;
  } entry_t;

  // Outcome of the position logic for one word.
  typedef struct packed {
    logic              status;
    logic [SLOT_W-1:0] slot;
    logic              pop_ok;
  } ctrl_res_t;

  // Keeps the payload bytes below min(len, 8).
  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < PAYLOAD_BYTES; b++) begin
      if (len > LEN_W'(b)) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

@@ hdl/cfrf_mem.sv @@
module cfrf_mem #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  cfrf_pkg::entry_t wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output cfrf_pkg::entry_t rdata_o
);

  cfrf_pkg::entry_t mem_q [DEPTH];
  cfrf_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/cfrf_ctrl.sv @@
module cfrf_ctrl #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned PW = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          op_i,
  output cfrf_pkg::ctrl_res_t res_o,
  output logic                we_o,
  output logic                re_o,
  output logic [AW-1:0]       addr_o
);

  localparam logic [PW-1:0] PDEPTH = PW'(DEPTH);

  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d, rp_v, idx;
  logic          wrap_q, wrap_d, wrap_v;
  cfrf_pkg::op_e op;

  assign op = cfrf_pkg::op_e'(op_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      wrap_q <= 1'b0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      wrap_q <= wrap_d;
    end
  end

  always_comb begin
    wp_d   = wp_q;
    rp_d   = rp_q;
    wrap_d = wrap_q;
    rp_v   = rp_q;
    wrap_v = wrap_q;
    idx    = '0;
    we_o   = 1'b0;
    re_o   = 1'b0;
    res_o  = '0;
    if (accept_i) begin
      case (op)
        cfrf_pkg::OP_PUSH: begin
          if (wrap_q ? (wp_q >= rp_q) : (wp_q == PDEPTH && rp_q == '0)) begin
            res_o.status = cfrf_pkg::ST_REJECT;
          end else begin
            idx = wp_q;
            // Write position at the end with room at the front: go round.
            if (!wrap_q && wp_q == PDEPTH) begin
              idx    = '0;
              wrap_d = 1'b1;
            end
            wp_d       = idx + PW'(1);
            we_o       = 1'b1;
            res_o.slot = cfrf_pkg::SLOT_W'(idx);
          end
        end
        cfrf_pkg::OP_POP: begin
          // The read position follows the writer round before the empty test,
          // and that move stands even when the pop is then rejected.
          if (wrap_q && rp_q == PDEPTH) begin
            rp_v   = '0;
            wrap_v = 1'b0;
          end
          rp_d   = rp_v;
          wrap_d = wrap_v;
          if (!wrap_v && rp_v >= wp_q) begin
            res_o.status = cfrf_pkg::ST_REJECT;
          end else begin
            idx          = rp_v;
            rp_d         = rp_v + PW'(1);
            re_o         = 1'b1;
            res_o.slot   = cfrf_pkg::SLOT_W'(idx);
            res_o.pop_ok = 1'b1;
          end
        end
        cfrf_pkg::OP_CLEAR: begin
          wp_d   = '0;
          rp_d   = '0;
          wrap_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign addr_o = AW'(idx);

endmodule

@@ hdl/can_frame_ring_fifo_top.sv @@
// Channel   Direction  Handshake                Words carried
// input     in         in_valid_i / in_stall_o  op, frame_id, frame_len, payload, stamp
// output    out        out_valid_o / out_stall_i status, slot, id, len, payload, stamp
//
// Every input word gives exactly one output word, passing the read stage and
// then the output register. With no output stall a new word is taken every
// cycle; the frame memory has a single read port and a registered read.
// Reset (rst_ni, asynchronous, active low) clears the positions, the wrap flag
// and the valid flags; frame memory contents are left undefined.
// An output stall holds the output register and then the read stage; the input
// stalls only when both are full and the output is stalled.
module can_frame_ring_fifo_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] frame_id_i,
  input  logic [7:0]  frame_len_i,
  input  logic [63:0] payload_i,
  input  logic [63:0] stamp_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [5:0]  slot_o,
  output logic [31:0] out_id_o,
  output logic [6:0]  out_len_o,
  output logic [63:0] out_payload_o,
  output logic [63:0] out_stamp_o
);

`include "can_frame_ring_fifo_top_assert.svh"

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                in_acc;
  logic                s1_adv;
  logic                s1_valid_q;
  cfrf_pkg::ctrl_res_t ctrl_res, s1_res_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_addr;
  cfrf_pkg::entry_t    wdata, rdata;
  logic [6:0]          len_sat;

  logic        out_valid_q;
  logic        status_q;
  logic [5:0]  slot_q;
  logic [31:0] id_q;
  logic [6:0]  len_q;
  logic [63:0] payload_q;
  logic [63:0] stamp_q;

  // The read stage moves on whenever the output register is free or drains.
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  cfrf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .op_i     (op_i),
    .res_o    (ctrl_res),
    .we_o     (mem_we),
    .re_o     (mem_re),
    .addr_o   (mem_addr)
  );

  // The stored length saturates at 64, and payload bytes past it are dropped
  // on the way in, so a pop can hand the stored word out as it is.
  assign len_sat = (frame_len_i > 8'(cfrf_pkg::LEN_MAX)) ? 7'(cfrf_pkg::LEN_MAX)
                                                         : frame_len_i[6:0];

  always_comb begin
    wdata.id      = frame_id_i;
    wdata.len     = len_sat;
    wdata.payload = payload_i & cfrf_pkg::byte_mask(len_sat);
    wdata.stamp   = stamp_i;
  end

  // A write lands at the edge of acceptance, so a pop accepted in the next
  // cycle already reads the new frame; no forwarding is needed.
  cfrf_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (wdata),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_res_q <= ctrl_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Frame fields are shown only for a successful pop and are zero otherwise.
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      status_q <= s1_res_q.status;
      slot_q   <= s1_res_q.slot;
      if (s1_res_q.pop_ok) begin
        id_q      <= rdata.id;
        len_q     <= rdata.len;
        payload_q <= rdata.payload;
        stamp_q   <= rdata.stamp;
      end else begin
        id_q      <= '0;
        len_q     <= '0;
        payload_q <= '0;
        stamp_q   <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign slot_o        = slot_q;
  assign out_id_o      = id_q;
  assign out_len_o     = len_q;
  assign out_payload_o = payload_q;
  assign out_stamp_o   = stamp_q;

  `CFRF_ASSERT_NEVER(a_reject_clean, clk_i, rst_ni, out_valid_q && status_q == cfrf_pkg::ST_REJECT && (slot_q != '0 || len_q != '0 || id_q != '0), "rejected word carries data")
  `CFRF_ASSERT_NEVER(a_len_range, clk_i, rst_ni, out_valid_q && len_q > 7'(cfrf_pkg::LEN_MAX), "stored length above 64")
  `CFRF_ASSERT_NEXT(a_accept_fills, clk_i, rst_ni, in_acc, s1_valid_q, "accepted word not in read stage")
  `CFRF_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, s1_valid_q && out_valid_q && out_stall_i, s1_valid_q && out_valid_q, "stalled word lost")

endmodule

@@ bench/tb.sv @@
module tb;

  // Ring size of the block under test; the mirror below keeps the same size.
  localparam int unsigned DEPTH = 64;

  // The tail wait covers the pipeline latency with plenty of room.
  localparam int unsigned TAIL_CYCLES = 20;

  // Roughly 600 words, each worth at most one sender idle gap, one receiver
  // stall and the pipeline latency. This limit is many times that.
  localparam int unsigned CYCLE_LIMIT = 200000;

  localparam int unsigned RANDOM_WORDS = 500;

  // One result word as the output channel carries it.
  typedef struct packed {
    logic                        status;
    logic [cfrf_pkg::SLOT_W-1:0] slot;
    logic [cfrf_pkg::ID_W-1:0]   id;
    logic [cfrf_pkg::LEN_W-1:0]  len;
    logic [cfrf_pkg::DATA_W-1:0] payload;
    logic [cfrf_pkg::DATA_W-1:0] stamp;
  } fifo_result_t;

  // Mirror of the frame ring. It tracks both positions, the wrap flag and the
  // stored frames, and it keeps the queue of result words still to come.
  class ring_fifo_mirror;
    logic [cfrf_pkg::LEN_W-1:0] wr_pos;
    logic [cfrf_pkg::LEN_W-1:0] rd_pos;
    logic                       wrapped;
    cfrf_pkg::entry_t           frames [DEPTH];
    fifo_result_t               awaited_words [$];
    int unsigned                errors;
    int unsigned n_stored, n_full, n_popped, n_empty, n_clear, n_wrap, n_ignored;

    function new();
      wr_pos    = '0;
      rd_pos    = '0;
      wrapped   = 1'b0;
      errors    = 0;
      n_stored  = 0;
      n_full    = 0;
      n_popped  = 0;
      n_empty   = 0;
      n_clear   = 0;
      n_wrap    = 0;
      n_ignored = 0;
    endfunction

    // Mask that keeps only the payload bytes below min(len, 8).
    function logic [cfrf_pkg::DATA_W-1:0] keep_bytes(logic [cfrf_pkg::LEN_W-1:0] len);
      int unsigned n;
      n = (len < cfrf_pkg::PAYLOAD_BYTES) ? len : cfrf_pkg::PAYLOAD_BYTES;
      if (n == cfrf_pkg::PAYLOAD_BYTES) begin
        return '1;
      end
      return (64'd1 << (n * 8)) - 64'd1;
    endfunction

    // Works out the result of one accepted input word and queues it.
    function void note_word(cfrf_pkg::op_e op, logic [cfrf_pkg::ID_W-1:0] id,
                            logic [cfrf_pkg::LEN_IN_W-1:0] len_in,
                            logic [cfrf_pkg::DATA_W-1:0] pl,
                            logic [cfrf_pkg::DATA_W-1:0] st);
      fifo_result_t               res;
      logic [cfrf_pkg::LEN_W-1:0] len;
      res = '0;
      case (op)
        cfrf_pkg::OP_PUSH: begin
          if ((wrapped && wr_pos >= rd_pos) ||
              (!wrapped && wr_pos == cfrf_pkg::LEN_W'(DEPTH) && rd_pos == '0)) begin
            res.status = cfrf_pkg::ST_REJECT;
            n_full++;
          end else begin
            if (!wrapped && wr_pos == cfrf_pkg::LEN_W'(DEPTH)) begin
              wrapped = 1'b1;
              wr_pos  = '0;
              n_wrap++;
            end
            len = (len_in > cfrf_pkg::LEN_MAX) ? cfrf_pkg::LEN_W'(cfrf_pkg::LEN_MAX)
                                               : len_in[cfrf_pkg::LEN_W-1:0];
            frames[wr_pos].id      = id;
            frames[wr_pos].len     = len;
            frames[wr_pos].payload = pl & keep_bytes(len);
            frames[wr_pos].stamp   = st;
            res.status = cfrf_pkg::ST_DONE;
            res.slot   = wr_pos[cfrf_pkg::SLOT_W-1:0];
            wr_pos     = wr_pos + 1'b1;
            n_stored++;
          end
        end
        cfrf_pkg::OP_POP: begin
          if (wrapped && rd_pos == cfrf_pkg::LEN_W'(DEPTH)) begin
            wrapped = 1'b0;
            rd_pos  = '0;
          end
          if (!wrapped && rd_pos >= wr_pos) begin
            res.status = cfrf_pkg::ST_REJECT;
            n_empty++;
          end else begin
            res.status  = cfrf_pkg::ST_DONE;
            res.slot    = rd_pos[cfrf_pkg::SLOT_W-1:0];
            res.id      = frames[rd_pos].id;
            res.len     = frames[rd_pos].len;
            res.payload = frames[rd_pos].payload & keep_bytes(frames[rd_pos].len);
            res.stamp   = frames[rd_pos].stamp;
            rd_pos      = rd_pos + 1'b1;
            n_popped++;
          end
        end
        cfrf_pkg::OP_CLEAR: begin
          wr_pos  = '0;
          rd_pos  = '0;
          wrapped = 1'b0;
          n_clear++;
        end
        default: begin
          n_ignored++;
        end
      endcase
      awaited_words.push_back(res);
    endfunction

    function void check_field(string name, logic [cfrf_pkg::DATA_W-1:0] want,
                              logic [cfrf_pkg::DATA_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // Compares one accepted result word with the oldest one awaited.
    function void check_word(fifo_result_t got);
      fifo_result_t want;
      if (awaited_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual %h", $time, got);
        return;
      end
      want = awaited_words.pop_front();
      check_field("status",  64'(want.status), 64'(got.status));
      check_field("slot",    64'(want.slot),   64'(got.slot));
      check_field("id",      64'(want.id),     64'(got.id));
      check_field("len",     64'(want.len),    64'(got.len));
      check_field("payload", want.payload,     got.payload);
      check_field("stamp",   want.stamp,       got.stamp);
    endfunction

    function int unsigned pending();
      return awaited_words.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  op_i;
  logic [31:0] frame_id_i;
  logic [7:0]  frame_len_i;
  logic [63:0] payload_i;
  logic [63:0] stamp_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        status_o;
  logic [5:0]  slot_o;
  logic [31:0] out_id_o;
  logic [6:0]  out_len_o;
  logic [63:0] out_payload_o;
  logic [63:0] out_stamp_o;

  can_frame_ring_fifo_top #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .frame_id_i   (frame_id_i),
    .frame_len_i  (frame_len_i),
    .payload_i    (payload_i),
    .stamp_i      (stamp_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .slot_o       (slot_o),
    .out_id_o     (out_id_o),
    .out_len_o    (out_len_o),
    .out_payload_o(out_payload_o),
    .out_stamp_o  (out_stamp_o)
  );

  ring_fifo_mirror mirror;

  // Handshake flags. They are written at the rising edge and read by the
  // drivers at the following falling edge, so no two processes touch them in
  // the same time step.
  logic        in_fire;
  logic        out_fire;
  logic        tx_steady;
  logic        rx_steady;
  int unsigned cycle_count;
  int unsigned sent_words;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Monitor: every input word accepted at this edge goes into the mirror,
  // and every output word accepted at this edge is checked against it.
  always @(posedge clk_i) begin
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    if (in_fire) begin
      mirror.note_word(cfrf_pkg::op_e'(op_i), frame_id_i, frame_len_i, payload_i, stamp_i);
    end
    if (out_fire) begin
      mirror.check_word('{status_o, slot_o, out_id_o, out_len_o, out_payload_o, out_stamp_o});
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding",
               cycle_count, mirror.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: before each result word it stalls for a drawn number of
  // cycles, then takes the word as soon as one is offered. The stall is not
  // tied to out_valid_o, so it lands on every phase of the pipeline.
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = rx_steady ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(negedge clk_i); while (!out_fire);
    end
  end

  // Sends one word. It idles for a drawn number of cycles, puts the word on
  // the port and holds it until it is accepted. Called at a falling edge and
  // returns at the falling edge after acceptance, so valid stays high across
  // back-to-back words without being lowered in between.
  task automatic send_word(cfrf_pkg::op_e op, logic [31:0] id, logic [7:0] len,
                           logic [63:0] pl, logic [63:0] st);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_i        = op;
    frame_id_i  = id;
    frame_len_i = len;
    payload_i   = pl;
    stamp_i     = st;
    in_valid_i  = 1'b1;
    do @(negedge clk_i); while (!in_fire);
    if (op != cfrf_pkg::OP_NONE) begin
      sent_words++;
    end
  endtask

  // Length mix: a quarter around the eight-byte boundary, the rest up to the
  // saturation point, above it and across the whole field.
  function automatic logic [7:0] random_len();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 8));
      1: return 8'($urandom_range(0, 64));
      2: return 8'($urandom_range(65, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_random();
    send_word(cfrf_pkg::OP_PUSH, $urandom, random_len(), {$urandom, $urandom},
              {$urandom, $urandom});
  endtask

  // Pops carry random junk in the unused fields; the block must ignore it.
  task automatic pop_word();
    send_word(cfrf_pkg::OP_POP, $urandom, 8'($urandom), {$urandom, $urandom},
              {$urandom, $urandom});
  endtask

  task automatic clear_word();
    send_word(cfrf_pkg::OP_CLEAR, $urandom, 8'($urandom), {$urandom, $urandom},
              {$urandom, $urandom});
  endtask

  initial begin
    int unsigned target;
    in_valid_i  = 1'b0;
    op_i        = cfrf_pkg::OP_NONE;
    frame_id_i  = '0;
    frame_len_i = '0;
    payload_i   = '0;
    stamp_i     = '0;
    out_stall_i = 1'b0;
    in_fire     = 1'b0;
    out_fire    = 1'b0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    cycle_count = 0;
    sent_words  = 0;
    mirror      = new();
    rst_ni      = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words. A pop on the empty ring right after reset and an
    // unused op come first, then pushes at the length extremes: zero length
    // drops the whole payload, seven keeps all but the top byte, and lengths
    // above 64 saturate.
    pop_word();
    send_word(cfrf_pkg::OP_NONE, '1, '1, '1, '1);
    send_word(cfrf_pkg::OP_PUSH, 32'h0000_0000, 8'd0, '1, 64'h0);
    send_word(cfrf_pkg::OP_PUSH, 32'hFFFF_FFFF, 8'd8, '1, '1);
    send_word(cfrf_pkg::OP_PUSH, $urandom, 8'd255, '1, {$urandom, $urandom});
    send_word(cfrf_pkg::OP_PUSH, $urandom, 8'd64, {$urandom, $urandom},
              {$urandom, $urandom});
    send_word(cfrf_pkg::OP_PUSH, $urandom, 8'd65, '1, '0);
    send_word(cfrf_pkg::OP_PUSH, $urandom, 8'd7, '1, '1);
    send_word(cfrf_pkg::OP_PUSH, $urandom, 8'd1, '1, {$urandom, $urandom});
    // Drain all seven and one more, which must come back empty.
    repeat (8) pop_word();
    // A clear with frames still queued leaves the ring empty.
    send_word(cfrf_pkg::OP_PUSH, $urandom, 8'd3, '1, '1);
    send_word(cfrf_pkg::OP_PUSH, $urandom, 8'd9, '1, '1);
    clear_word();
    pop_word();
    send_word(cfrf_pkg::OP_PUSH, $urandom, 8'd4, '1, '1);
    pop_word();

    // Random part. The first tour is a fixed shape with random content: it
    // fills the ring past full, the write position wrapping at the end, frees
    // a few slots and fills again, then drains past the end of the ring until
    // pops come back empty.
    target = sent_words + RANDOM_WORDS;
    repeat (70) push_random();
    repeat (10) pop_word();
    repeat (15) push_random();
    repeat (70) pop_word();

    // After that, bursts of random kind. Long push and pop runs keep the ring
    // moving between empty, full and wrapped; the noise bursts mix in
    // clears and unused ops at random points.
    while (sent_words < target) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          repeat ($urandom_range(30, 70)) push_random();
        end
        3, 4, 5: begin
          repeat ($urandom_range(30, 70)) pop_word();
        end
        6, 7: begin
          repeat (20) begin
            if ($urandom_range(0, 1) == 0) begin
              push_random();
            end else begin
              pop_word();
            end
          end
        end
        8: begin
          clear_word();
          repeat (5) push_random();
        end
        default: begin
          repeat (10) begin
            send_word(cfrf_pkg::op_e'($urandom_range(0, 3)), $urandom, random_len(),
                      {$urandom, $urandom}, {$urandom, $urandom});
          end
        end
      endcase
    end
    in_valid_i = 1'b0;
    rx_steady  = 1'b0;

    // Wait for every awaited result word, then a little longer so that a
    // stray extra word would still show up.
    while (mirror.pending() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Run covered %0d stored frames, %0d pops, %0d clears and %0d ignored words,",
             mirror.n_stored, mirror.n_popped, mirror.n_clear, mirror.n_ignored);
    $display("with %0d pushes refused as full, %0d pops refused as empty and %0d wraps.",
             mirror.n_full, mirror.n_empty, mirror.n_wrap);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/cfrf_pkg.sv
hdl/cfrf_mem.sv
hdl/cfrf_ctrl.sv
hdl/can_frame_ring_fifo_top.sv
bench/tb.sv
